/* src/ctfm_pkg.sv */
package ctfm_pkg;

    // Table and data sizes
    localparam int KEY_SLOTS  = 8;
    localparam int LEVEL_BITS = 16;
    localparam int IDX_W      = $clog2(KEY_SLOTS);
    localparam int CNT_W      = $clog2(KEY_SLOTS + 1);
    localparam int CH_BITS    = 8;
    localparam int CHANNELS   = 4;
    localparam int COLOR_BITS = CH_BITS * CHANNELS;
    localparam int WORK_BITS  = LEVEL_BITS + CH_BITS;
    localparam int DIV_STEPS  = CH_BITS;
    localparam int DCNT_W     = $clog2(DIV_STEPS);

    // Item kinds
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_MAP    = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic clear;
        logic scan;
        logic insert;
        logic mul;
        logic div;
        logic out_load;
    } ctfm_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] mode;
        logic       full;
        logic       empty;
        logic       scan_stop;
        logic       scan_first;
        logic       scan_end;
    } ctfm_stat_t;

endpackage

/* src/color_transfer_function_map.sv */
// Clear, an insert on a full table, a map on an empty table and an unused mode go from
// decode straight to the result; an insert scans the keys and then writes the new one, and
// a map scans the keys, then multiplies and divides unless the scan stops at the first key
// or past the last. One item in flight: a new item is taken the cycle after its
// predecessor's result is loaded. The key scan walks one key a cycle and the divider
// resolves one quotient bit a cycle for all four channels. Reset clears the key count, the
// swap register and both handshakes; key storage is not cleared.
module color_transfer_function_map
    import ctfm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // intensity[15:0], color_left[47:16], color_right[79:48]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // color[31:0]
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    ctfm_cmd_t  cmd;
    ctfm_stat_t stat;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    ctfm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ctfm_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_write   (cfg_valid),
        .cfg_swap    (cfg_data),
        .mode        (s_tuser),
        .intensity   (s_tdata[15:0]),
        .color_left  (s_tdata[47:16]),
        .color_right (s_tdata[79:48]),
        .color       (m_tdata),
        .status      (m_tuser)
    );

endmodule

/* src/ctfm_ctrl.sv */
module ctfm_ctrl
    import ctfm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  ctfm_stat_t stat,
    output ctfm_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_INSERT = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_DIV    = 3'd5;
    localparam logic [2:0] ST_RESULT = 3'd6;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [DCNT_W-1:0] dcnt_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Sequence one item at a time
    always_comb
    begin
        state_next = state_reg;
        dcnt_next  = dcnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (stat.mode)
                    MODE_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_RESULT;
                    end
                    MODE_INSERT:
                        state_next = stat.full ? ST_RESULT : ST_SCAN;
                    MODE_MAP:
                        state_next = stat.empty ? ST_RESULT : ST_SCAN;
                    default:
                        state_next = ST_RESULT;
                endcase
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_stop)
                begin
                    if (stat.mode == MODE_INSERT)
                        state_next = ST_INSERT;
                    else if (stat.scan_first || stat.scan_end)
                        state_next = ST_RESULT;
                    else
                        state_next = ST_MUL;
                end
            end
            ST_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = ST_RESULT;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                dcnt_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div   = 1'b1;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(DIV_STEPS - 1))
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Hold the result until the output transaction completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* src/ctfm_dpath.sv */
module ctfm_dpath
    import ctfm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctfm_cmd_t             cmd,
    output ctfm_stat_t            stat,
    input  logic                  cfg_write,
    input  logic                  cfg_swap,
    input  logic [1:0]            mode,
    input  logic [15:0]           intensity,
    input  logic [COLOR_BITS-1:0] color_left,
    input  logic [COLOR_BITS-1:0] color_right,
    output logic [COLOR_BITS-1:0] color,
    output logic [1:0]            status
);

    // Key table
    logic [LEVEL_BITS-1:0] key_level_reg [KEY_SLOTS];
    logic [COLOR_BITS-1:0] key_left_reg  [KEY_SLOTS];
    logic [COLOR_BITS-1:0] key_right_reg [KEY_SLOTS];
    logic [CNT_W-1:0]      count_reg;
    logic                  swap_reg;

    // Current item
    logic [1:0]            mode_reg;
    logic [LEVEL_BITS-1:0] level_reg;
    logic [COLOR_BITS-1:0] cl_reg;
    logic [COLOR_BITS-1:0] cr_reg;
    logic                  full_reg;
    logic                  empty_reg;

    // Search
    logic [CNT_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      pos_reg;
    logic                  first_reg;
    logic                  end_reg;
    logic [LEVEL_BITS-1:0] lo_level_reg;
    logic [COLOR_BITS-1:0] lo_right_reg;
    logic [LEVEL_BITS-1:0] hi_level_reg;
    logic [COLOR_BITS-1:0] hi_left_reg;
    logic [LEVEL_BITS-1:0] scan_level;
    logic                  in_range;
    logic                  greater;

    // Interpolation lanes
    logic [WORK_BITS-1:0]  work_reg [CHANNELS];
    logic                  neg_reg  [CHANNELS];
    logic [LEVEL_BITS-1:0] den_reg;
    logic [LEVEL_BITS-1:0] num;
    logic [COLOR_BITS-1:0] blend;
    logic [COLOR_BITS-1:0] mapped;

    // Output
    logic [COLOR_BITS-1:0] color_reg;
    logic [1:0]            status_reg;
    logic [COLOR_BITS-1:0] color_next;
    logic [1:0]            status_next;

    // Compare the sample with the key under the scan pointer
    assign scan_level = key_level_reg[idx_reg[IDX_W-1:0]];
    assign in_range   = (idx_reg != count_reg);
    assign greater    = in_range && (level_reg > scan_level);

    assign stat.mode       = mode_reg;
    assign stat.full       = full_reg;
    assign stat.empty      = empty_reg;
    assign stat.scan_stop  = !greater;
    assign stat.scan_first = (idx_reg == '0);
    assign stat.scan_end   = !in_range;

    assign num = level_reg - lo_level_reg;

    // Control state: count, swap, scan pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            swap_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (cfg_write)
                swap_reg <= cfg_swap;
            if (cmd.load)
                idx_reg <= '0;
            else if (cmd.scan && greater)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.clear)
                count_reg <= '0;
            else if (cmd.insert)
                count_reg <= count_reg + 1'b1;
        end
    end

    // Capture the item and the search bounds
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= mode;
            level_reg <= LEVEL_BITS'(intensity);
            cl_reg    <= color_left;
            cr_reg    <= color_right;
            full_reg  <= (count_reg == CNT_W'(KEY_SLOTS));
            empty_reg <= (count_reg == '0);
        end
        if (cmd.scan)
        begin
            if (greater)
            begin
                lo_level_reg <= scan_level;
                lo_right_reg <= key_right_reg[idx_reg[IDX_W-1:0]];
            end
            else
            begin
                if (in_range)
                begin
                    hi_level_reg <= scan_level;
                    hi_left_reg  <= key_left_reg[idx_reg[IDX_W-1:0]];
                end
                pos_reg   <= idx_reg;
                first_reg <= (idx_reg == '0);
                end_reg   <= !in_range;
            end
        end
    end

    // Open a gap at the insert position and write the new key
    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            if (pos_reg == '0)
            begin
                key_level_reg[0] <= level_reg;
                key_left_reg[0]  <= cl_reg;
                key_right_reg[0] <= cr_reg;
            end
            for (int i = 1; i < KEY_SLOTS; i++)
            begin
                if (CNT_W'(i) == pos_reg)
                begin
                    key_level_reg[i] <= level_reg;
                    key_left_reg[i]  <= cl_reg;
                    key_right_reg[i] <= cr_reg;
                end
                else if (CNT_W'(i) > pos_reg && CNT_W'(i) <= count_reg)
                begin
                    key_level_reg[i] <= key_level_reg[i-1];
                    key_left_reg[i]  <= key_left_reg[i-1];
                    key_right_reg[i] <= key_right_reg[i-1];
                end
            end
        end
    end

    // Multiply the channel difference by the offset, then divide one bit a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
            den_reg <= hi_level_reg - lo_level_reg;
        for (int c = 0; c < CHANNELS; c++)
        begin
            logic [CH_BITS-1:0]  b;
            logic [CH_BITS-1:0]  t;
            logic [CH_BITS-1:0]  mag;
            logic [LEVEL_BITS:0] trial;
            b     = lo_right_reg[c*CH_BITS +: CH_BITS];
            t     = hi_left_reg[c*CH_BITS +: CH_BITS];
            mag   = (t < b) ? (b - t) : (t - b);
            trial = {work_reg[c][WORK_BITS-1:CH_BITS], work_reg[c][CH_BITS-1]};
            if (cmd.mul)
            begin
                neg_reg[c]  <= (t < b);
                work_reg[c] <= {{LEVEL_BITS{1'b0}}, mag} * {{CH_BITS{1'b0}}, num};
            end
            else if (cmd.div)
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    trial       = trial - {1'b0, den_reg};
                    work_reg[c] <= {trial[LEVEL_BITS-1:0], work_reg[c][CH_BITS-2:0], 1'b1};
                end
                else
                begin
                    work_reg[c] <= {trial[LEVEL_BITS-1:0], work_reg[c][CH_BITS-2:0], 1'b0};
                end
            end
        end
    end

    // Apply the signed quotient to the lower key's right color
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (neg_reg[c])
                blend[c*CH_BITS +: CH_BITS] = lo_right_reg[c*CH_BITS +: CH_BITS]
                                              - work_reg[c][CH_BITS-1:0];
            else
                blend[c*CH_BITS +: CH_BITS] = lo_right_reg[c*CH_BITS +: CH_BITS]
                                              + work_reg[c][CH_BITS-1:0];
        end
    end

    // Pick the mapped color and form the result
    always_comb
    begin
        if (first_reg)
            mapped = hi_left_reg;
        else if (end_reg)
            mapped = lo_right_reg;
        else
            mapped = blend;

        color_next  = '0;
        status_next = STAT_OK;
        case (mode_reg)
            MODE_INSERT:
            begin
                if (full_reg)
                    status_next = STAT_FULL;
            end
            MODE_MAP:
            begin
                if (empty_reg)
                    status_next = STAT_EMPTY;
                else if (swap_reg)
                    color_next = {mapped[31:24], mapped[7:0], mapped[15:8], mapped[23:16]};
                else
                    color_next = mapped;
            end
            default:
            begin
                color_next  = '0;
                status_next = STAT_OK;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            color_reg  <= color_next;
            status_reg <= status_next;
        end
    end

    assign color  = color_reg;
    assign status = status_reg;

endmodule

/* bench/color_transfer_function_map_test.sv */
module color_transfer_function_map_test;
    import ctfm_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1000;
    localparam int MAX_GAP      = 10;
    localparam int DRAIN_CYCLES = 40;

    typedef enum logic [1:0] {JOB_ITEM, JOB_SETTLE, JOB_SWAP} job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [1:0]  mode;
        logic [15:0] level;
        logic [31:0] left;
        logic [31:0] right;
        logic        swap;
    } job_t;

    typedef struct packed {
        logic [31:0] color;
        logic [1:0]  status;
    } color_result_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata   = '0;   // intensity[15:0], color_left[47:16], color_right[79:48]
    logic [1:0]  s_tuser   = '0;   // mode[1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // color[31:0]
    logic [1:0]  m_tuser;          // status[1:0]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;

    // Stimulus plan and results still owed by the block
    job_t          pending_jobs[$];
    color_result_t expected_results[$];
    logic [15:0]   plan_levels[$];
    int            planned_items = 0;

    // Predicted key table and swap register
    logic [LEVEL_BITS-1:0] key_level_tab [KEY_SLOTS];
    logic [COLOR_BITS-1:0] key_left_tab  [KEY_SLOTS];
    logic [COLOR_BITS-1:0] key_right_tab [KEY_SLOTS];
    int                    key_total    = 0;
    logic                  swap_setting = 1'b0;

    // Handshake flags seen at the last rising edge
    logic in_taken  = 1'b0;
    logic out_taken = 1'b0;
    logic cfg_taken = 1'b0;

    // Idle control
    int   send_gap   = 0;
    int   recv_stall = 0;
    logic send_burst = 1'b0;
    logic recv_burst = 1'b0;

    // Bookkeeping
    int cycle_count  = 0;
    int mismatches   = 0;
    int n_clears     = 0;
    int n_inserts    = 0;
    int n_dropped    = 0;
    int n_maps       = 0;
    int n_blended    = 0;
    int n_empty_maps = 0;
    int n_ignored    = 0;
    int swap_writes  = 0;

    color_transfer_function_map uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Apply one accepted transaction to the key table and return its result
    function automatic void compute_color_result(
        input  logic [1:0]  mode,
        input  logic [15:0] level,
        input  logic [31:0] left,
        input  logic [31:0] right,
        output color_result_t res
    );
        int          pos;
        int          k;
        int          ch;
        int unsigned b, t, num, den, q;
        logic [31:0] sum;
        logic [31:0] rgba;
        res.color  = '0;
        res.status = STAT_OK;
        case (mode)
            MODE_CLEAR:
            begin
                key_total = 0;
                n_clears++;
            end
            MODE_INSERT:
            begin
                n_inserts++;
                if (key_total >= KEY_SLOTS)
                begin
                    res.status = STAT_FULL;
                    n_dropped++;
                end
                else
                begin
                    // Equal levels land in front of the stored ones
                    pos = 0;
                    while (pos < key_total && level > key_level_tab[pos])
                        pos++;
                    for (k = key_total; k > pos; k--)
                    begin
                        key_level_tab[k] = key_level_tab[k-1];
                        key_left_tab[k]  = key_left_tab[k-1];
                        key_right_tab[k] = key_right_tab[k-1];
                    end
                    key_level_tab[pos] = level;
                    key_left_tab[pos]  = left;
                    key_right_tab[pos] = right;
                    key_total++;
                end
            end
            MODE_MAP:
            begin
                n_maps++;
                if (key_total == 0)
                begin
                    res.status = STAT_EMPTY;
                    n_empty_maps++;
                end
                else
                begin
                    pos = 0;
                    while (pos < key_total && level > key_level_tab[pos])
                        pos++;
                    if (pos == 0)
                        rgba = key_left_tab[0];
                    else if (pos >= key_total)
                        rgba = key_right_tab[key_total-1];
                    else
                    begin
                        // Blend from the lower key's right color toward the upper key's left
                        num = level - key_level_tab[pos-1];
                        den = key_level_tab[pos] - key_level_tab[pos-1];
                        for (ch = 0; ch < CHANNELS; ch++)
                        begin
                            b = key_right_tab[pos-1][ch*CH_BITS +: CH_BITS];
                            t = key_left_tab[pos][ch*CH_BITS +: CH_BITS];
                            if (t >= b)
                                q = ((t - b) * num) / den;
                            else
                                q = -(((b - t) * num) / den);
                            sum = b + q;
                            rgba[ch*CH_BITS +: CH_BITS] = sum[CH_BITS-1:0];
                        end
                        n_blended++;
                    end
                    if (swap_setting)
                        rgba = {rgba[31:24], rgba[7:0], rgba[15:8], rgba[23:16]};
                    res.color = rgba;
                end
            end
            default:
                n_ignored++;
        endcase
    endfunction

    function automatic logic [31:0] draw_color();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] clamp_level(input int v);
        if (v < 0)
            return 16'h0000;
        if (v > 65535)
            return 16'hFFFF;
        return v[15:0];
    endfunction

    // Queue one transaction and track which keys the table will hold
    task automatic add_item(
        input logic [1:0]  mode,
        input logic [15:0] level,
        input logic [31:0] left,
        input logic [31:0] right
    );
        job_t job;
        job.kind  = JOB_ITEM;
        job.mode  = mode;
        job.level = level;
        job.left  = left;
        job.right = right;
        job.swap  = 1'b0;
        pending_jobs.insert(pending_jobs.size(), job);
        planned_items++;
        if (mode == MODE_CLEAR)
            plan_levels.delete();
        else if (mode == MODE_INSERT && plan_levels.size() < KEY_SLOTS)
            plan_levels.insert(plan_levels.size(), level);
    endtask

    task automatic add_control(input job_kind_t kind, input logic swap);
        job_t job;
        job       = '0;
        job.kind  = kind;
        job.swap  = swap;
        pending_jobs.insert(pending_jobs.size(), job);
    endtask

    initial
    begin : stimulus
        int          span_choice[5];
        int          directed;
        int          episode;
        int          base;
        int          span;
        int          nkeys;
        int          nmaps;
        int          i;
        int          pick;
        logic [15:0] probe;
        logic [31:0] left;

        // Directed: empty map, fill past capacity, each map region, unused mode
        add_control(JOB_SWAP, 1'b0);
        add_item(MODE_MAP, 16'd0, 32'h0, 32'h0);
        add_item(MODE_INSERT, 16'd1000, 32'h0000_0000, 32'hFFFF_FFFF);
        add_item(MODE_INSERT, 16'd3000, 32'hFFFF_FFFF, 32'h0000_0000);
        add_item(MODE_INSERT, 16'd1000, 32'h80FF_0001, 32'h7F00_FFFE);
        add_item(MODE_INSERT, 16'd0,    32'h1122_3344, 32'h5566_7788);
        add_item(MODE_INSERT, 16'd60000, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        add_item(MODE_INSERT, 16'd2000, 32'h0102_0304, 32'hFEFD_FCFB);
        add_item(MODE_INSERT, 16'd3001, 32'h0000_FF00, 32'hFF00_FF00);
        add_item(MODE_INSERT, 16'd65534, 32'h3C3C_C3C3, 32'hC3C3_3C3C);
        add_item(MODE_INSERT, 16'd500,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(MODE_MAP, 16'd0,     32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(MODE_MAP, 16'd999,   32'h0, 32'h0);
        add_item(MODE_MAP, 16'd1000,  32'h0, 32'h0);
        add_item(MODE_MAP, 16'd1001,  32'h0, 32'h0);
        add_item(MODE_MAP, 16'd1500,  32'h0, 32'h0);
        add_item(MODE_MAP, 16'd3000,  32'h0, 32'h0);
        add_item(MODE_MAP, 16'd3001,  32'h0, 32'h0);
        add_item(MODE_MAP, 16'd40000, 32'h0, 32'h0);
        add_item(MODE_MAP, 16'hFFFF,  32'h0, 32'h0);
        add_item(MODE_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_control(JOB_SETTLE, 1'b0);
        add_control(JOB_SWAP, 1'b1);
        add_item(MODE_MAP, 16'd1500, 32'h0, 32'h0);
        add_item(MODE_MAP, 16'hFFFF, 32'h0, 32'h0);
        add_control(JOB_SETTLE, 1'b0);
        add_control(JOB_SWAP, 1'b0);
        add_item(MODE_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(MODE_MAP, 16'd1500, 32'h0, 32'h0);
        directed = planned_items;

        // Random: clear, build a table with clustered levels, then map into it; some maps are noise
        span_choice = '{0, 15, 255, 4095, 65535};
        episode = 0;
        while (planned_items < directed + RANDOM_ITEMS)
        begin
            if (episode % 6 == 5)
            begin
                add_control(JOB_SETTLE, 1'b0);
                add_control(JOB_SWAP, ((episode / 6) % 2) == 0);
            end
            span = span_choice[$urandom_range(0, 4)];
            base = $urandom_range(0, 65535);
            add_item(MODE_CLEAR, 16'($urandom), $urandom, $urandom);
            nkeys = $urandom_range(1, KEY_SLOTS + 1);
            for (i = 0; i < nkeys; i++)
            begin
                left = draw_color();
                add_item(MODE_INSERT, clamp_level(base + $urandom_range(0, span)), left,
                         ($urandom_range(0, 3) == 0) ? left : draw_color());
            end
            nmaps = $urandom_range(4, 24);
            for (i = 0; i < nmaps; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // Noise: any mode with any content
                    add_item(2'($urandom_range(0, 3)), 16'($urandom), $urandom, $urandom);
                end
                else
                begin
                    pick = $urandom_range(0, 7);
                    if (pick <= 1 && plan_levels.size() > 0)
                        probe = plan_levels[$urandom_range(0, plan_levels.size() - 1)];
                    else if (pick == 2 && plan_levels.size() > 0)
                        probe = clamp_level(int'(plan_levels[$urandom_range(0,
                                plan_levels.size() - 1)]) + ($urandom_range(0, 1) ? 1 : -1));
                    else if (pick == 3)
                        probe = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    else
                        probe = clamp_level(base - span / 8 + $urandom_range(0, span + span / 4));
                    add_item(MODE_MAP, probe, $urandom, $urandom);
                end
            end
            episode++;
        end

        // Hold reset, then release it away from the rising edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_jobs.size() != 0 || s_tvalid || cfg_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d transactions: %0d clears, %0d inserts (%0d dropped on a full table),",
                 planned_items, n_clears, n_inserts, n_dropped);
        $display("%0d maps (%0d blended, %0d on an empty table), %0d unused-mode, %0d swap writes",
                 n_maps, n_blended, n_empty_maps, n_ignored, swap_writes);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Drive inputs on the falling edge
    always @(negedge clk)
    begin : driver
        logic v_next;
        logic c_next;
        job_t head;
        if (rst_n)
        begin
            // Drop valids once their transaction has gone through
            v_next = s_tvalid && !in_taken;
            c_next = cfg_valid && !cfg_taken;
            if (!v_next && !c_next && pending_jobs.size() > 0)
            begin
                if (send_gap > 0)
                    send_gap--;
                else
                begin
                    head = pending_jobs[0];
                    case (head.kind)
                        JOB_ITEM:
                        begin
                            s_tdata  <= {head.right, head.left, head.level};
                            s_tuser  <= head.mode;
                            v_next   = 1'b1;
                            send_gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
                            void'(pending_jobs.pop_front());
                        end
                        JOB_SETTLE:
                        begin
                            if (expected_results.size() == 0)
                                void'(pending_jobs.pop_front());
                        end
                        default:
                        begin
                            // Write the swap register only with nothing in flight
                            if (expected_results.size() == 0)
                            begin
                                cfg_data <= head.swap;
                                c_next   = 1'b1;
                                void'(pending_jobs.pop_front());
                            end
                        end
                    endcase
                end
            end
            if ($urandom_range(0, 39) == 0)
                send_burst = !send_burst;
            s_tvalid  <= v_next;
            cfg_valid <= c_next;

            // Stall the result side at random after each result
            if (out_taken)
                recv_stall = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 39) == 0)
                recv_burst = !recv_burst;
            if (recv_stall > 0)
            begin
                m_tready <= 1'b0;
                recv_stall--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Sample handshakes on the rising edge, predict and check
    always @(posedge clk)
    begin : monitor
        color_result_t want;
        cycle_count++;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: color %h, status %0d", m_tdata, m_tuser);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want.color)
                    begin
                        $error("color mismatch: expected %h, actual %h", want.color, m_tdata);
                        mismatches++;
                    end
                    if (m_tuser !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d", want.status, m_tuser);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                compute_color_result(s_tuser, s_tdata[15:0], s_tdata[47:16], s_tdata[79:48],
                                     want);
                expected_results.insert(expected_results.size(), want);
            end
            if (cfg_valid && cfg_ready)
            begin
                swap_setting = cfg_data;
                swap_writes++;
            end
        end
        in_taken  <= rst_n && s_tvalid && s_tready;
        out_taken <= rst_n && m_tvalid && m_tready;
        cfg_taken <= rst_n && cfg_valid && cfg_ready;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("status: fail");
            $finish;
        end
    end

endmodule

/* files.f */
src/ctfm_pkg.sv
src/ctfm_ctrl.sv
src/ctfm_dpath.sv
src/color_transfer_function_map.sv
bench/color_transfer_function_map_test.sv
